// File: rtl/pls_pkg.sv
// shared types and constants for the periodic laplacian stencil
// used by pls_mac and periodic_laplacian_stencil; no dependencies
package pls_pkg;

    // grid is 32 cells per axis; coordinates index it directly and wrap mod 32
    localparam int GRID_N  = 32;
    localparam int CRD_W   = $clog2(GRID_N);
    localparam int ADDR_W  = 3 * CRD_W;
    localparam int DEPTH   = GRID_N * GRID_N * GRID_N;

    localparam int DATA_W  = 32;
    localparam int COEF_W  = 32;
    localparam int HALF_W  = COEF_W / 2;
    localparam int TERM_W  = DATA_W + 3;          // a + b - 2c, exact
    localparam int PROD_W  = TERM_W + HALF_W + 1; // term times one coefficient half
    localparam int ACC_W   = 70;                  // three terms times full coefficient

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } t_axis;

    typedef struct packed {
        logic  vld;
        logic  first;
        logic  last;
        t_axis axis;
    } t_term;

endpackage

// File: rtl/pls_mac.sv
// scaling and accumulation of the three axis terms, final round and saturate
// depends on pls_pkg
module pls_mac (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pls_pkg::t_term                i_term,
    input  logic signed [pls_pkg::TERM_W-1:0] i_t,
    input  logic [pls_pkg::COEF_W-1:0]    i_coef_x,
    input  logic [pls_pkg::COEF_W-1:0]    i_coef_y,
    input  logic [pls_pkg::COEF_W-1:0]    i_coef_z,
    input  logic                          i_three_dim,
    output logic                          o_valid,
    output logic signed [pls_pkg::DATA_W-1:0] o_laplacian
);
    import pls_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sh8000_0000);

    logic [COEF_W-1:0]        coef;
    logic signed [TERM_W-1:0] t_in;
    logic signed [PROD_W-1:0] r_plo, r_phi;
    logic                     r_p_vld, r_p_first, r_p_last;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic                     r_a_done;
    logic signed [ACC_W-1:0]  neg_acc, shifted;
    logic                     r_valid;
    logic signed [DATA_W-1:0] r_lap, n_lap;

    always_comb begin
        case (i_term.axis)
            AXIS_X:  coef = i_coef_x;
            AXIS_Y:  coef = i_coef_y;
            AXIS_Z:  coef = i_three_dim ? i_coef_z : '0;
            default: coef = '0;
        endcase
    end

    // in 2d mode the z neighbours may never have been written, drop the term
    assign t_in = (i_term.axis == AXIS_Z && !i_three_dim) ? '0 : i_t;

    // product stage: low and high coefficient halves
    always_ff @(posedge i_clk) begin
        if (i_term.vld) begin
            r_plo <= t_in * $signed({1'b0, coef[HALF_W-1:0]});
            r_phi <= t_in * $signed({1'b0, coef[COEF_W-1:HALF_W]});
        end
        r_p_first <= i_term.first;
        r_p_last  <= i_term.last;
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_term.vld;
        end
    end

    always_comb begin
        n_acc = (r_p_first ? '0 : r_acc)
              + {{(ACC_W-PROD_W){r_plo[PROD_W-1]}}, r_plo}
              + {{(ACC_W-PROD_W-HALF_W){r_phi[PROD_W-1]}}, r_phi, {HALF_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (r_p_vld) begin
            r_acc <= n_acc;
        end
        if (!i_rst_n) begin
            r_a_done <= 1'b0;
        end else begin
            r_a_done <= r_p_vld && r_p_last;
        end
    end

    // floor(-S / 2^16) is an arithmetic shift of the negated sum
    always_comb begin
        neg_acc = -r_acc;
        shifted = neg_acc >>> HALF_W;
        if (shifted > SAT_MAX) begin
            n_lap = DATA_W'(SAT_MAX);
        end else if (shifted < SAT_MIN) begin
            n_lap = DATA_W'(SAT_MIN);
        end else begin
            n_lap = shifted[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_done) begin
            r_lap <= n_lap;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_a_done;
        end
    end

    assign o_valid     = r_valid;
    assign o_laplacian = r_lap;

endmodule

// File: rtl/periodic_laplacian_stencil.sv
// periodic seven-point negative laplacian over a 32x32x32 q16.16 grid
// depends on pls_pkg and pls_mac
//
// command channel: a transaction is taken at a clock edge where i_start is
// high and o_busy is low. a write command (i_command = 0) stores i_cell_value
// at the addressed cell in that same edge and never raises o_busy, so writes
// go at one per cycle while o_busy is low. a compute command (i_command = 1)
// raises o_busy, reads the center and its six wrapped neighbours from the
// single-port grid memory, one read per cycle, and scales each axis term by
// its coefficient. the result is shown on o_laplacian and o_out_x/y/z for
// one cycle with o_valid high; o_busy drops in the cycle after, and the next
// command is taken once o_busy is low. the result passes through the seven
// memory reads and the term, product, accumulate and saturate stages.
// the receiver cannot stall.
// in 2d mode the z coordinate is taken as zero and o_out_z reads zero.
// config channel: i_cfg_valid with o_cfg_ready (always high) writes register
// i_cfg_index; write only while the block is idle.
// reset (synchronous, active low) clears control and restores coefficients
// to 1.0 and 3d mode; grid contents are undefined until written.
module periodic_laplacian_stencil (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_command,
    input  logic [pls_pkg::CRD_W-1:0]         i_cell_x,
    input  logic [pls_pkg::CRD_W-1:0]         i_cell_y,
    input  logic [pls_pkg::CRD_W-1:0]         i_cell_z,
    input  logic signed [pls_pkg::DATA_W-1:0] i_cell_value,
    output logic                              o_valid,
    output logic signed [pls_pkg::DATA_W-1:0] o_laplacian,
    output logic [pls_pkg::CRD_W-1:0]         o_out_x,
    output logic [pls_pkg::CRD_W-1:0]         o_out_y,
    output logic [pls_pkg::CRD_W-1:0]         o_out_z,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [pls_pkg::COEF_W-1:0]        i_cfg_data
);
    import pls_pkg::*;

    typedef enum logic [1:0] {
        CFG_COEF_X,
        CFG_COEF_Y,
        CFG_COEF_Z,
        CFG_THREE_DIM
    } t_cfg_reg;

    typedef enum logic [2:0] {
        RD_CTR,
        RD_XP,
        RD_XM,
        RD_YP,
        RD_YM,
        RD_ZP,
        RD_ZM
    } t_rd_idx;

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(65536);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [COEF_W-1:0] r_coef_x, r_coef_y, r_coef_z;
    logic              r_three_dim;

    logic              r_busy;
    logic              r_rd_act;
    t_rd_idx           r_rd_idx;
    logic [CRD_W-1:0]  r_x, r_y, r_z;
    logic [CRD_W-1:0]  z_in;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic              wr_en, cmp_go;

    logic [DATA_W-1:0] r_q;
    logic              r_q_vld;
    t_rd_idx           r_q_idx;
    logic [DATA_W-1:0] r_ctr, r_pair;
    logic signed [TERM_W-1:0] r_t, n_t;
    t_term             r_term;

    logic              mac_valid;

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_x    <= COEF_ONE;
            r_coef_y    <= COEF_ONE;
            r_coef_z    <= COEF_ONE;
            r_three_dim <= 1'b1;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_COEF_X:    r_coef_x    <= i_cfg_data;
                CFG_COEF_Y:    r_coef_y    <= i_cfg_data;
                CFG_COEF_Z:    r_coef_z    <= i_cfg_data;
                CFG_THREE_DIM: r_three_dim <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // command acceptance and read sequencing
    assign z_in    = r_three_dim ? i_cell_z : '0;
    assign wr_en   = i_start && !r_busy && !i_command;
    assign cmp_go  = i_start && !r_busy && i_command;
    assign wr_addr = {z_in, i_cell_y, i_cell_x};

    always_ff @(posedge i_clk) begin
        if (cmp_go) begin
            r_x <= i_cell_x;
            r_y <= i_cell_y;
            r_z <= z_in;
        end
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_rd_act <= 1'b0;
            r_rd_idx <= RD_CTR;
        end else if (cmp_go) begin
            r_busy   <= 1'b1;
            r_rd_act <= 1'b1;
            r_rd_idx <= RD_CTR;
        end else begin
            if (mac_valid) begin
                r_busy <= 1'b0;
            end
            if (r_rd_act) begin
                if (r_rd_idx == RD_ZM) begin
                    r_rd_act <= 1'b0;
                end else begin
                    r_rd_idx <= t_rd_idx'(3'(r_rd_idx + 3'd1));
                end
            end
        end
    end

    // neighbour coordinates wrap by truncation on a power-of-two grid
    always_comb begin
        case (r_rd_idx)
            RD_CTR:  rd_addr = {r_z, r_y, r_x};
            RD_XP:   rd_addr = {r_z, r_y, CRD_W'(r_x + 1'b1)};
            RD_XM:   rd_addr = {r_z, r_y, CRD_W'(r_x - 1'b1)};
            RD_YP:   rd_addr = {r_z, CRD_W'(r_y + 1'b1), r_x};
            RD_YM:   rd_addr = {r_z, CRD_W'(r_y - 1'b1), r_x};
            RD_ZP:   rd_addr = {CRD_W'(r_z + 1'b1), r_y, r_x};
            RD_ZM:   rd_addr = {CRD_W'(r_z - 1'b1), r_y, r_x};
            default: rd_addr = {r_z, r_y, r_x};
        endcase
    end

    // single-port grid memory, writes only while idle and reads only while busy
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_cell_value;
        end else if (r_rd_act) begin
            r_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_idx <= r_rd_idx;
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else begin
            r_q_vld <= r_rd_act;
        end
    end

    // axis term a + b - 2c once the second neighbour arrives
    always_comb begin
        n_t = $signed({{3{r_pair[DATA_W-1]}}, r_pair})
            + $signed({{3{r_q[DATA_W-1]}}, r_q})
            - $signed({{2{r_ctr[DATA_W-1]}}, r_ctr, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (r_q_vld) begin
            case (r_q_idx)
                RD_CTR:                r_ctr  <= r_q;
                RD_XP, RD_YP, RD_ZP:   r_pair <= r_q;
                RD_XM, RD_YM, RD_ZM:   r_t    <= n_t;
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            r_term <= '0;
        end else begin
            r_term.vld   <= r_q_vld && (r_q_idx == RD_XM || r_q_idx == RD_YM
                                        || r_q_idx == RD_ZM);
            r_term.first <= (r_q_idx == RD_XM);
            r_term.last  <= (r_q_idx == RD_ZM);
            case (r_q_idx)
                RD_XM:   r_term.axis <= AXIS_X;
                RD_YM:   r_term.axis <= AXIS_Y;
                default: r_term.axis <= AXIS_Z;
            endcase
        end
    end

    pls_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_term      (r_term),
        .i_t         (r_t),
        .i_coef_x    (r_coef_x),
        .i_coef_y    (r_coef_y),
        .i_coef_z    (r_coef_z),
        .i_three_dim (r_three_dim),
        .o_valid     (mac_valid),
        .o_laplacian (o_laplacian)
    );

    assign o_busy  = r_busy;
    assign o_valid = mac_valid;
    assign o_out_x = r_x;
    assign o_out_y = r_y;
    assign o_out_z = r_z;

    // a result only leaves while its compute transaction is still open
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("result strobe outside a compute transaction");

    a_go_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmp_go |=> o_busy && r_rd_act)
        else $error("compute accepted without starting reads");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_act |-> !r_q_vld || r_term.vld == 1'b0 || !o_valid)
        else $error("reads overlap a finishing result");

    a_read_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_act |-> r_busy && !wr_en)
        else $error("grid read outside a busy compute");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_busy && !o_valid)
        else $error("control not cleared by reset");

endmodule
